/* rtl/core/owmr_pkg.sv */
// ----------------------------------------------------------------------------
// owmr_pkg - shared types and constants of the omni wheel mixer
// Fixed-point mixing weights, register indexes, mode codes and helpers.
// ----------------------------------------------------------------------------
package owmr_pkg;

    // wheel speed / target value
    typedef logic signed [15:0] speed_t;
    typedef speed_t [2:0] wheels_t;

    // mixing accumulator, wide enough for a sum of three Q16 products
    typedef logic signed [35:0] acc_t;

    // Q16 mixing weights
    localparam acc_t Q16_COS30 = 36'sd56755;

    // configuration register indexes
    localparam logic [7:0] REG_VELOCITY_LIMIT = 8'd0;
    localparam logic [7:0] REG_RAMP_STEP      = 8'd1;

    // register reset values
    localparam logic [14:0] LIMIT_RESET = 15'd17000;
    localparam logic [14:0] RAMP_RESET  = 15'd500;

    // mode codes as seen on the result channel
    localparam logic [1:0] MODE_CODE_REMOTE = 2'd0;
    localparam logic [1:0] MODE_CODE_VISION = 2'd1;
    localparam logic [1:0] MODE_CODE_STOP   = 2'd2;

    // Q16 accumulator to a 16-bit target: truncate toward zero, saturate
    function automatic speed_t q16_to_target(input acc_t acc);
        acc_t             adj;
        logic signed [19:0] q;
        begin
            adj = acc + ((acc < 0) ? 36'sd65535 : 36'sd0);
            q   = 20'(adj >>> 16);
            if (q > 20'sd32767) begin
                q16_to_target = 16'sh7FFF;
            end else if (q < -20'sd32768) begin
                q16_to_target = 16'sh8000;
            end else begin
                q16_to_target = q[15:0];
            end
        end
    endfunction

endpackage

/* rtl/core/owmr_mix.sv */
// ----------------------------------------------------------------------------
// owmr_mix - three wheel omni kinematics mixer
// Maps the remote axes and the vision speeds to two sets of wheel targets.
// ----------------------------------------------------------------------------
module owmr_mix
    import owmr_pkg::*;
(
    input  speed_t  remote_x,
    input  speed_t  remote_y,
    input  speed_t  remote_turn,
    input  speed_t  vision_x,
    input  speed_t  vision_y,
    input  speed_t  vision_yaw,
    output wheels_t remote_target,
    output wheels_t vision_target
);

    acc_t ry_cos;
    acc_t rx_half;
    acc_t rt_half;
    acc_t rx_full;
    acc_t vx_cos;
    acc_t vy_half;
    acc_t vw_quarter;

    // weighted terms: one constant multiply per input set, the rest are shifts
    assign ry_cos     = acc_t'(remote_y) * Q16_COS30;
    assign rx_half    = acc_t'(remote_x) <<< 15;
    assign rt_half    = acc_t'(remote_turn) <<< 15;
    assign rx_full    = acc_t'(remote_x) <<< 16;
    assign vx_cos     = acc_t'(vision_x) * Q16_COS30;
    assign vy_half    = acc_t'(vision_y) <<< 15;
    assign vw_quarter = acc_t'(vision_yaw) <<< 14;

    // remote mixing
    assign remote_target[0] = q16_to_target(ry_cos + rx_half + rt_half);
    assign remote_target[1] = q16_to_target(rx_half + rt_half - ry_cos);
    assign remote_target[2] = q16_to_target(rt_half - rx_full);

    // vision mixing (speeds in thousandths, the 1000 scale cancels)
    assign vision_target[0] = q16_to_target(vx_cos - vy_half - vw_quarter);
    assign vision_target[1] = q16_to_target(-vx_cos - vy_half - vw_quarter);
    assign vision_target[2] = q16_to_target(vy_half - vw_quarter);

endmodule

/* rtl/core/omni_wheel_mixer_with_ramp_unit.sv */
// ----------------------------------------------------------------------------
// omni_wheel_mixer_with_ramp_unit - omni drive mixer with slew-rate limiter
// Mode keys, kinematic mixing, target clamp and per-tick velocity ramp.
// ----------------------------------------------------------------------------
// Items are taken into an input register and processed, once the output is
// free, by one pass of mixing, clamping and ramping into the result register,
// with the wheel state updated in that same cycle. One item is accepted every
// cycle unless a held result stalls the input; a result occupies the output
// register until taken, and the input register holds one more item behind it.
// A control tick (tuser = 0) goes from the input register to the output
// register, raising m_tvalid; a vision packet (tuser = 1) updates the targets
// in vision mode and gives no result. The user must write registers through
// the cfg channel only while no item is in flight; the block won't enforce it.
// ----------------------------------------------------------------------------
module omni_wheel_mixer_with_ramp_unit
    import owmr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [14:0]  cfg_data,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata, low to high: key_up, key_left, key_down, remote_x, remote_y,
    // remote_turn, vision_x, vision_y, vision_yaw, zero pad
    input  logic [103:0] s_tdata,
    // tuser: func
    input  logic [0:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata, low to high: wheel_one_speed, wheel_two_speed,
    // wheel_three_speed, current_mode, zero pad
    output logic [55:0]  m_tdata
);

    typedef enum logic [2:0] {
        REMOTE = 3'b001,
        VISION = 3'b010,
        STOP   = 3'b100
    } mode_t;

    logic [14:0] limit_reg;
    logic [14:0] step_reg;
    mode_t       mode_reg, mode_next;
    wheels_t     target_reg, target_next;
    wheels_t     vel_reg, vel_next;

    logic         in_v_reg;
    logic         in_func_reg;
    logic [98:0]  in_data_reg;
    logic         out_v_reg, out_v_next;
    logic [55:0]  out_data_reg, out_data_next;

    logic    advance;
    logic    proc;
    logic    tick;
    wheels_t remote_target;
    wheels_t vision_target;
    logic [1:0] mode_code;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
            step_reg  <= RAMP_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_VELOCITY_LIMIT: limit_reg <= cfg_data;
                REG_RAMP_STEP:      step_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake: the work stage moves when the output register is free
    assign advance  = !out_v_reg || m_tready;
    assign s_tready = !in_v_reg || advance;
    assign proc     = in_v_reg && advance;
    assign tick     = proc && !in_func_reg;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_tready) begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg <= s_tuser[0];
            in_data_reg <= s_tdata[98:0];
        end
    end

    // kinematics
    owmr_mix u_mix (
        .remote_x      (in_data_reg[18:3]),
        .remote_y      (in_data_reg[34:19]),
        .remote_turn   (in_data_reg[50:35]),
        .vision_x      (in_data_reg[66:51]),
        .vision_y      (in_data_reg[82:67]),
        .vision_yaw    (in_data_reg[98:83]),
        .remote_target (remote_target),
        .vision_target (vision_target)
    );

    // mode keys, mixing, clamp and ramp
    always_comb begin
        logic signed [16:0] lim17;
        logic signed [16:0] step17;
        logic signed [16:0] t17;
        logic signed [16:0] diff;
        logic signed [16:0] moved;
        wheels_t            tgt;

        mode_next     = mode_reg;
        target_next   = target_reg;
        vel_next      = vel_reg;
        out_v_next    = out_v_reg && !m_tready;
        out_data_next = out_data_reg;
        mode_code     = MODE_CODE_REMOTE;
        lim17         = $signed({2'b00, limit_reg});
        step17        = $signed({2'b00, step_reg});
        tgt           = target_reg;
        t17           = '0;
        diff          = '0;
        moved         = '0;

        if (proc && in_func_reg) begin
            // vision packet
            if (mode_reg == VISION) begin
                target_next = vision_target;
            end
        end else if (tick) begin
            if (in_data_reg[0]) mode_next = VISION;
            if (in_data_reg[1]) mode_next = REMOTE;
            if (in_data_reg[2]) begin
                mode_next = STOP;
                tgt       = '0;
            end
            if (mode_next == REMOTE) begin
                tgt = remote_target;
            end

            for (int i = 0; i < 3; i++) begin
                // clamp to the velocity limit
                t17 = 17'(tgt[i]);
                if (t17 > lim17) t17 = lim17;
                if (t17 < -lim17) t17 = -lim17;
                target_next[i] = t17[15:0];
                // one ramp step toward the target
                diff = t17 - 17'(vel_reg[i]);
                if (diff > 17'sd0) begin
                    moved = (diff > step17) ? 17'(vel_reg[i]) + step17 : t17;
                end else if (diff < -step17) begin
                    moved = 17'(vel_reg[i]) - step17;
                end else begin
                    moved = t17;
                end
                vel_next[i] = moved[15:0];
            end

            case (mode_next)
                REMOTE:  mode_code = MODE_CODE_REMOTE;
                VISION:  mode_code = MODE_CODE_VISION;
                STOP:    mode_code = MODE_CODE_STOP;
                default: mode_code = MODE_CODE_REMOTE;
            endcase

            out_v_next    = 1'b1;
            out_data_next = {6'b0, mode_code, vel_next[2], vel_next[1], vel_next[0]};
        end
    end

    // wheel state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= REMOTE;
            target_reg <= '0;
            vel_reg    <= '0;
            out_v_reg  <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            target_reg <= target_next;
            vel_reg    <= vel_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    // input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_v_reg && out_v_reg && !m_tready))
        else $error("input stalled without a held result");

    // a vision packet never moves the wheel velocities
    a_vision_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_func_reg) |=> $stable(vel_reg))
        else $error("vision packet changed a wheel velocity");

    // a tick moves the first wheel velocity by no more than the ramp step
    a_ramp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tick |=> ((18'($signed(vel_reg[0])) - 18'($signed($past(vel_reg[0]))))
                  <= $signed({3'b000, $past(step_reg)}))
              && ((18'($signed($past(vel_reg[0]))) - 18'($signed(vel_reg[0])))
                  <= $signed({3'b000, $past(step_reg)})))
        else $error("wheel velocity stepped beyond the ramp step");

    // after a tick the second stored target lies inside the limit
    a_target_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        tick |=> ((17'($signed(target_reg[1])) <= $signed({2'b00, $past(limit_reg)}))
              && (-17'($signed(target_reg[1])) <= $signed({2'b00, $past(limit_reg)}))))
        else $error("wheel target outside the velocity limit");

    // a tick always lands a result in the output register
    a_tick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        tick |=> out_v_reg)
        else $error("control tick produced no result");

endmodule

/* dv/omni_wheel_mixer_with_ramp_unit_tb.sv */
// ----------------------------------------------------------------------------
// omni_wheel_mixer_with_ramp_unit_tb - self-checking bench of the wheel mixer
// Drives control ticks and vision packets over the input stream and predicts
// mode, targets and ramped wheel speeds. Each result transfer is checked in
// order against the prediction, across several limit and ramp settings.
// ----------------------------------------------------------------------------
module omni_wheel_mixer_with_ramp_unit_tb;
    import owmr_pkg::*;

    // Q16 mixing weights
    localparam longint W_COS30   = 56755;
    localparam longint W_HALF    = 32768;
    localparam longint W_QUARTER = 16384;
    localparam longint W_ONE     = 65536;

    localparam int SETTLE_CYCLES = 6;     // covers a vision packet still in flight
    localparam int QUIET_LIMIT   = 5000;  // cycles without any transfer
    localparam int PHASE_ITEMS   = 80;
    localparam logic [7:0] REG_FIRST_UNMAPPED = 8'd2;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [7:0]    cfg_index = '0;
    logic [14:0]   cfg_data = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    // key_up, key_left, key_down, remote_x/y/turn, vision_x/y/yaw, zero pad
    logic [103:0]  s_tdata = '0;
    // func
    logic [0:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    // wheel_one/two/three_speed, current_mode, zero pad
    logic [55:0]   m_tdata;

    bit steady = 1'b0;  // no idling on either side while set
    int counted = 0;    // input transfers that have an effect

    // clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    omni_wheel_mixer_with_ramp_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    typedef struct {
        logic              func;
        logic              key_up;
        logic              key_left;
        logic              key_down;
        logic signed [15:0] remote_x;
        logic signed [15:0] remote_y;
        logic signed [15:0] remote_turn;
        logic signed [15:0] vision_x;
        logic signed [15:0] vision_y;
        logic signed [15:0] vision_yaw;
    } wheel_cmd_t;

    typedef struct {
        speed_t     speed [3];
        logic [1:0] mode;
    } wheel_speeds_t;

    // ------------------------------------------------------------------------
    // Mode, target and velocity tracker with the queue of speeds still due
    // ------------------------------------------------------------------------
    class wheel_ramp_tracker;
        int            limit;
        int            step;
        logic [1:0]    mode;
        int            target [3];
        int            velocity [3];
        wheel_speeds_t speeds_due [$];
        int            errors;

        function new();
            limit = LIMIT_RESET;
            step  = RAMP_RESET;
            mode  = MODE_CODE_REMOTE;
            foreach (target[i]) begin
                target[i]   = 0;
                velocity[i] = 0;
            end
            errors = 0;
        endfunction

        function void set_reg(logic [7:0] idx, logic [14:0] val);
            if (idx == REG_VELOCITY_LIMIT) begin
                limit = val;
            end else if (idx == REG_RAMP_STEP) begin
                step = val;
            end
        endfunction

        // divide by 2^16 toward zero, then saturate to 16 bits
        static function int to_target(longint acc);
            longint q;
            q = acc / W_ONE;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            return int'(q);
        endfunction

        static function int ramp(int goal, int now, int stp);
            int diff;
            diff = goal - now;
            if (diff > 0) return now + ((diff > stp) ? stp : diff);
            if (diff < -stp) return now - stp;
            return goal;
        endfunction

        // returns 0 for an item that the block ignores
        function bit note_input(wheel_cmd_t c);
            wheel_speeds_t due;
            longint        ax, ay, aw;
            if (c.func) begin
                if (mode != MODE_CODE_VISION) return 1'b0;
                ax = c.vision_x;
                ay = c.vision_y;
                aw = c.vision_yaw;
                target[0] = to_target(ax * W_COS30 - ay * W_HALF - aw * W_QUARTER);
                target[1] = to_target(-ax * W_COS30 - ay * W_HALF - aw * W_QUARTER);
                target[2] = to_target(ay * W_HALF - aw * W_QUARTER);
                return 1'b1;
            end
            // later key wins
            if (c.key_up) mode = MODE_CODE_VISION;
            if (c.key_left) mode = MODE_CODE_REMOTE;
            if (c.key_down) begin
                mode = MODE_CODE_STOP;
                foreach (target[i]) target[i] = 0;
            end
            if (mode == MODE_CODE_REMOTE) begin
                ax = c.remote_x;
                ay = c.remote_y;
                aw = c.remote_turn;
                target[0] = to_target(ay * W_COS30 + ax * W_HALF + aw * W_HALF);
                target[1] = to_target(-ay * W_COS30 + ax * W_HALF + aw * W_HALF);
                target[2] = to_target(-ax * W_ONE + aw * W_HALF);
            end
            // clamp stored targets, then slew each velocity
            foreach (target[i]) begin
                if (target[i] > limit) target[i] = limit;
                if (target[i] < -limit) target[i] = -limit;
                velocity[i]  = ramp(target[i], velocity[i], step);
                due.speed[i] = speed_t'(velocity[i]);
            end
            due.mode = mode;
            speeds_due.push_back(due);
            return 1'b1;
        endfunction

        task flag_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task compare_speeds(logic [55:0] data);
            wheel_speeds_t due;
            speed_t        got;
            if (speeds_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result %h", data));
                return;
            end
            due = speeds_due.pop_front();
            for (int i = 0; i < 3; i++) begin
                got = data[16*i +: 16];
                if (got !== due.speed[i]) begin
                    flag_mismatch($sformatf("wheel %0d speed %0d, expected %0d",
                                            i + 1, got, due.speed[i]));
                end
            end
            if (data[49:48] !== due.mode) begin
                flag_mismatch($sformatf("mode %0d, expected %0d", data[49:48], due.mode));
            end
        endtask
    endclass

    wheel_ramp_tracker tracker;

    // idle with a chance of 6 in 100, never while steady
    function automatic bit take_break();
        return !steady && ($urandom_range(99) < 6);
    endfunction

    function automatic logic signed [15:0] pick_axis();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sd0;
            3, 4, 5: return 16'($signed($urandom_range(4000)) - 2000);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic wheel_cmd_t random_cmd(bit func);
        wheel_cmd_t c;
        c.func        = func;
        c.key_up      = 1'b0;
        c.key_left    = 1'b0;
        c.key_down    = 1'b0;
        c.remote_x    = pick_axis();
        c.remote_y    = pick_axis();
        c.remote_turn = pick_axis();
        c.vision_x    = pick_axis();
        c.vision_y    = pick_axis();
        c.vision_yaw  = pick_axis();
        return c;
    endfunction

    function automatic wheel_cmd_t make_cmd(bit func, bit up, bit left, bit down,
                                            int rx, int ry, int rt, int vx, int vy, int vw);
        wheel_cmd_t c;
        c.func        = func;
        c.key_up      = up;
        c.key_left    = left;
        c.key_down    = down;
        c.remote_x    = 16'(rx);
        c.remote_y    = 16'(ry);
        c.remote_turn = 16'(rt);
        c.vision_x    = 16'(vx);
        c.vision_y    = 16'(vy);
        c.vision_yaw  = 16'(vw);
        return c;
    endfunction

    // one input transfer; valid stays high for a following item
    task automatic send_cmd(wheel_cmd_t c);
        while (take_break()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.func;
        s_tdata  <= {5'b0, c.vision_yaw, c.vision_y, c.vision_x, c.remote_turn,
                     c.remote_y, c.remote_x, c.key_down, c.key_left, c.key_up};
        do @(posedge aclk); while (!s_tready);
        if (tracker.note_input(c)) counted++;
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.speeds_due.size() != 0) @(posedge aclk);
    endtask

    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register writes back to back; optional write to an unmapped index first
    task automatic program_limits(logic [14:0] lim, logic [14:0] stp, bit with_unmapped);
        logic [7:0]  idx [$];
        logic [14:0] val [$];
        if (with_unmapped) begin
            idx.push_back(8'($urandom_range(255, REG_FIRST_UNMAPPED)));
            val.push_back(15'($urandom));
        end
        idx.push_back(REG_VELOCITY_LIMIT);
        val.push_back(lim);
        idx.push_back(REG_RAMP_STEP);
        val.push_back(stp);
        foreach (idx[i]) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            tracker.set_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // extremes, mode changes and the special cases at reset settings
    task automatic run_directed();
        send_cmd(make_cmd(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(0, 0, 0, 0, 32767, 32767, 32767, 0, 0, 0));
        send_cmd(make_cmd(0, 0, 0, 0, -32768, -32768, -32768, 0, 0, 0));
        send_cmd(make_cmd(0, 0, 0, 0, -32768, 32767, 0, 0, 0, 0));
        // vision packet in remote mode is dropped
        send_cmd(make_cmd(1, 0, 0, 0, 0, 0, 0, 32767, 32767, 32767));
        send_cmd(make_cmd(0, 1, 0, 0, 1234, -999, 77, 0, 0, 0));
        send_cmd(make_cmd(1, 0, 0, 0, 0, 0, 0, 32767, -32768, -32768));
        send_cmd(make_cmd(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(1, 0, 0, 0, 0, 0, 0, -32768, 32767, 32767));
        // small values where truncation toward zero matters
        send_cmd(make_cmd(1, 0, 0, 0, 0, 0, 0, 1000, -1, 3));
        send_cmd(make_cmd(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // down key clears targets, then ramp toward zero
        send_cmd(make_cmd(0, 0, 0, 1, 5000, 5000, 5000, 0, 0, 0));
        send_cmd(make_cmd(0, 0, 0, 0, 5000, 5000, 5000, 0, 0, 0));
        send_cmd(make_cmd(1, 0, 0, 0, 0, 0, 0, 20000, 20000, 20000));
        send_cmd(make_cmd(0, 1, 1, 0, -1, 1, -1, 0, 0, 0));
        send_cmd(make_cmd(0, 1, 1, 1, 30000, 30000, 30000, 0, 0, 0));
        send_cmd(make_cmd(0, 1, 0, 1, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(0, 0, 1, 0, 0, 12345, -32768, 0, 0, 0));
        send_cmd(make_cmd(0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        // keys and remote fields of a vision packet are ignored
        send_cmd(make_cmd(1, 1, 1, 1, 32767, -32768, 32767, -5, 7, -32768));
        send_cmd(make_cmd(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // well-formed mode sequences with random content, plus some noise
    task automatic run_traffic(int n, bit pause_mid);
        wheel_cmd_t c;
        int         start;
        int         kind;
        bit         paused;
        start  = counted;
        paused = 1'b0;
        while (counted - start < n) begin
            if (pause_mid && !paused && (counted - start >= n / 2)) begin
                hold_until_drained();
                paused = 1'b1;
            end
            kind = $urandom_range(9);
            if (kind <= 3) begin
                c = random_cmd(1'b0);
                c.key_left = 1'b1;
                send_cmd(c);
                repeat ($urandom_range(8, 3)) send_cmd(random_cmd($urandom_range(99) < 10));
            end else if (kind <= 7) begin
                c = random_cmd(1'b0);
                c.key_up = 1'b1;
                send_cmd(c);
                repeat ($urandom_range(10, 4)) send_cmd(random_cmd($urandom_range(99) < 55));
            end else if (kind == 8) begin
                c = random_cmd(1'b0);
                c.key_down = 1'b1;
                send_cmd(c);
                repeat ($urandom_range(5, 2)) send_cmd(random_cmd(1'($urandom_range(1))));
            end else begin
                repeat ($urandom_range(5, 2)) begin
                    c = random_cmd(1'($urandom_range(1)));
                    c.key_up   = 1'($urandom_range(1));
                    c.key_left = 1'($urandom_range(1));
                    c.key_down = 1'($urandom_range(1));
                    send_cmd(c);
                end
            end
        end
    endtask

    // result side: check every transfer, stall at random
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                tracker.compare_speeds(m_tdata);
            end
            m_tready <= !take_break();
        end
    end

    // watchdog on cycles without any transfer
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        logic [14:0] lim;
        logic [14:0] stp;
        tracker = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        for (int phase = 0; phase < 6; phase++) begin
            settle();
            case (phase)
                0: begin
                    lim = 15'h7FFF;
                    stp = 15'h7FFF;
                end
                1: begin
                    lim = 15'd0;
                    stp = 15'd0;
                end
                2: begin
                    lim = 15'($urandom_range(32767));
                    stp = 15'($urandom_range(32767));
                end
                3: begin
                    lim = 15'($urandom_range(32767, 1000));
                    stp = 15'($urandom_range(4000, 1));
                end
                default: begin
                    lim = 15'($urandom_range(32767));
                    stp = 15'($urandom_range(3000, 1));
                end
            endcase
            program_limits(lim, stp, phase == 2);
            steady = (phase == 3);
            run_traffic((phase == 1) ? PHASE_ITEMS / 2 : PHASE_ITEMS, phase == 4);
            steady = 1'b0;
        end
        settle();
        if (tracker.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/owmr_pkg.sv
rtl/core/owmr_mix.sv
rtl/core/omni_wheel_mixer_with_ramp_unit.sv
dv/omni_wheel_mixer_with_ramp_unit_tb.sv
